// ----- rtl/core/cqf_pkg.sv -----
// Shared constants and types for the circular queue FIFO.
`timescale 1ns / 1ps
package cqf_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_DEQ  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	// write side of the entry store
	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} ram_wr_t;

	// status captured when an item is accepted
	typedef struct packed {
		logic ok;
		logic empty;
		logic full;
		cnt_t count;
	} status_t;

endpackage

// ----- rtl/core/cqf_ram.sv -----
// Entry store: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
module cqf_ram (
	input  logic           clk,
	input  cqf_pkg::ram_wr_t wr,
	input  cqf_pkg::idx_t  raddr_a,
	input  cqf_pkg::idx_t  raddr_b,
	output cqf_pkg::word_t rdata_a,
	output cqf_pkg::word_t rdata_b
);
	import cqf_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/core/circular_queue_fifo.sv -----
// Circular queue FIFO of signed 32-bit words with a settable capacity.
//
// Input channel (s_*): one item per handshake; s_tuser carries the action
// (enqueue, dequeue, peek), s_tdata the word to enqueue.
// Output channel (m_*): exactly one result per input item, in order.
// m_tuser carries ok; m_tdata carries front, rear, empty, full and count,
// all as they stand after the action. Front and rear read zero when empty.
// APB port: register 0, at any address with paddr[2] low, is the capacity
// (1..16). An out-of-range write is ignored; a valid write empties the queue.
//
// Timing: when an item is accepted, its pointer update and store write happen
// at that edge and the read addresses are registered; in ST_RD the entry
// store reads front and rear, and in ST_OUT the result is loaded into the
// output register once that register is free. No new item is taken until
// then. A new item is taken while a result waits in the output register;
// if the receiver stalls, the following result holds in the store's read
// registers (state ST_OUT) until the output register frees up.
// Reset empties the queue and sets the capacity to 16; the store contents
// are not cleared.
`timescale 1ns / 1ps
module circular_queue_fifo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // push_value[31:0]
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // front[31:0], rear[63:32], empty[64], full[65],
	                              // count[70:66], zero pad[71]
	output logic [0:0]  m_tuser,  // ok[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cqf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	idx_t       head_q, tail_q;
	cnt_t       count_q, cap_q;
	status_t    stat_q;
	idx_t       raddr_a_q, raddr_b_q;

	logic       m_valid_q;
	logic [71:0] m_data_q;
	logic       m_ok_q;

	ram_wr_t    wr;
	word_t      rdata_a, rdata_b;

	logic       accept, cfg_wr, cap_valid;
	logic       enq_ok, deq_ok, out_load;
	idx_t       head_n, tail_n, last_n;
	cnt_t       count_n;
	logic [1:0] action;

	function automatic idx_t wrap_next(idx_t idx, cnt_t cap);
		cnt_t n;
		n = cnt_t'(idx) + cnt_t'(1);
		return (n >= cap) ? idx_t'(0) : n[IDX_W-1:0];
	endfunction

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign cap_valid = (pwdata != 32'd0) && (pwdata <= 32'(DEPTH));
	assign prdata   = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, cap_q} : 32'd0;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign action   = s_tuser;

	assign enq_ok = (action == ACT_ENQ) && (count_q < cap_q);
	assign deq_ok = (action == ACT_DEQ) && (count_q != cnt_t'(0));

	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		if (enq_ok) begin
			tail_n  = wrap_next(tail_q, cap_q);
			count_n = count_q + cnt_t'(1);
		end else if (deq_ok) begin
			head_n  = wrap_next(head_q, cap_q);
			count_n = count_q - cnt_t'(1);
		end
		last_n = (tail_n == idx_t'(0)) ? idx_t'(cap_q - cnt_t'(1)) : tail_n - idx_t'(1);
	end

	assign wr.en   = accept && enq_ok;
	assign wr.addr = tail_q;
	assign wr.data = s_tdata;

	cqf_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.raddr_a (raddr_a_q),
		.raddr_b (raddr_b_q),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= cnt_t'(DEPTH);
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && cap_valid) begin
				cap_q   <= pwdata[CNT_W-1:0];
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (accept) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end

			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RD;
				ST_RD:   state_q <= ST_OUT;
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raddr_a_q    <= head_n;
			raddr_b_q    <= last_n;
			stat_q.ok    <= enq_ok || deq_ok ||
			                ((action == ACT_PEEK) && (count_q != cnt_t'(0)));
			stat_q.empty <= (count_n == cnt_t'(0));
			stat_q.full  <= (count_n == cap_q);
			stat_q.count <= count_n;
		end
		if (out_load) begin
			m_ok_q   <= stat_q.ok;
			m_data_q <= {1'b0, stat_q.count, stat_q.full, stat_q.empty,
			             stat_q.empty ? word_t'(0) : rdata_b,
			             stat_q.empty ? word_t'(0) : rdata_a};
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_ok_q;

endmodule
